[sv/mce_pkg.sv]
// Package for the Morse character encoder: widths, codes, tables and shared types.
`default_nettype none

package mce_pkg;

  // Payload widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned PinW   = 6;
  localparam int unsigned UnitsW = 2;
  localparam int unsigned CountW = 3;   // up to four symbols per letter
  localparam int unsigned PatW   = 4;   // dot/dash pattern, first symbol in the MSB
  localparam int unsigned IdxW   = 5;   // letter index 0..25

  // Segment lengths in time units
  localparam logic [UnitsW-1:0] DOT_ON_UNITS     = 2'd1;
  localparam logic [UnitsW-1:0] DASH_ON_UNITS    = 2'd3;
  localparam logic [UnitsW-1:0] SYMBOL_OFF_UNITS = 2'd1;
  localparam logic [UnitsW-1:0] SPACE_UNITS      = 2'd1;
  localparam logic [UnitsW-1:0] GAP_UNITS        = 2'd2;

  // ASCII codes
  localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM_ON,
    ST_SYM_OFF,
    ST_SPACE,
    ST_GAP
  } state_e;

  // Character class
  typedef enum logic [1:0] {
    KIND_LETTER,
    KIND_SPACE,
    KIND_OTHER
  } kind_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;   // capture a new character
    logic              emit;   // write a segment into the output register
    logic              level;
    logic [UnitsW-1:0] units;
    logic              last;
    logic              shift;  // advance to the next symbol
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_e in_kind;    // class of the character on the input channel
    logic  last_sym;   // current symbol is the final one of the letter
    logic  dash;       // current symbol is a dash
    logic  slot_free;  // output register can take a segment this cycle
  } dp_status_t;

  // Number of symbols per letter
  function automatic logic [CountW-1:0] sym_count(input logic [IdxW-1:0] idx);
    logic [CountW-1:0] c;
    c = '0;
    unique case (idx)
      5'd0:  c = 3'd2;  5'd1:  c = 3'd4;  5'd2:  c = 3'd4;  5'd3:  c = 3'd3;
      5'd4:  c = 3'd1;  5'd5:  c = 3'd4;  5'd6:  c = 3'd3;  5'd7:  c = 3'd4;
      5'd8:  c = 3'd2;  5'd9:  c = 3'd4;  5'd10: c = 3'd3;  5'd11: c = 3'd4;
      5'd12: c = 3'd2;  5'd13: c = 3'd2;  5'd14: c = 3'd3;  5'd15: c = 3'd4;
      5'd16: c = 3'd4;  5'd17: c = 3'd3;  5'd18: c = 3'd3;  5'd19: c = 3'd1;
      5'd20: c = 3'd3;  5'd21: c = 3'd4;  5'd22: c = 3'd3;  5'd23: c = 3'd4;
      5'd24: c = 3'd4;  5'd25: c = 3'd4;
      default: c = 3'd1;
    endcase
    return c;
  endfunction

  // Dot/dash pattern per letter, right aligned, 1 = dash
  function automatic logic [PatW-1:0] sym_bits(input logic [IdxW-1:0] idx);
    logic [PatW-1:0] b;
    b = '0;
    unique case (idx)
      5'd0:  b = 4'd1;  5'd1:  b = 4'd8;  5'd2:  b = 4'd10; 5'd3:  b = 4'd4;
      5'd4:  b = 4'd0;  5'd5:  b = 4'd2;  5'd6:  b = 4'd6;  5'd7:  b = 4'd0;
      5'd8:  b = 4'd0;  5'd9:  b = 4'd7;  5'd10: b = 4'd5;  5'd11: b = 4'd4;
      5'd12: b = 4'd3;  5'd13: b = 4'd2;  5'd14: b = 4'd7;  5'd15: b = 4'd6;
      5'd16: b = 4'd13; 5'd17: b = 4'd2;  5'd18: b = 4'd0;  5'd19: b = 4'd1;
      5'd20: b = 4'd1;  5'd21: b = 4'd1;  5'd22: b = 4'd3;  5'd23: b = 4'd9;
      5'd24: b = 4'd11; 5'd25: b = 4'd12;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  // Move the first symbol of a pattern into the MSB
  function automatic logic [PatW-1:0] align_pat(input logic [PatW-1:0] bits,
                                                input logic [CountW-1:0] cnt);
    logic [PatW-1:0] a;
    a = bits;
    unique case (cnt)
      3'd1:    a = {bits[0],   3'b000};
      3'd2:    a = {bits[1:0], 2'b00};
      3'd3:    a = {bits[2:0], 1'b0};
      default: a = bits;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[sv/mce_if.sv]
// Valid/ready channel interfaces for the character input and the segment output.
`default_nettype none

interface mce_in_if;
  logic                        valid;
  logic                        ready;
  logic [mce_pkg::CharW-1:0]   character;
  logic [mce_pkg::PinW-1:0]    led_pin;

  modport source (output valid, character, led_pin, input ready);
  modport sink   (input valid, character, led_pin, output ready);
endinterface

interface mce_out_if;
  logic                        valid;
  logic                        ready;
  logic [mce_pkg::PinW-1:0]    out_pin;
  logic                        level;
  logic [mce_pkg::UnitsW-1:0]  units;
  logic                        last;

  modport source (output valid, out_pin, level, units, last, input ready);
  modport sink   (input valid, out_pin, level, units, last, output ready);
endinterface

`default_nettype wire

[sv/morse_character_encoder_top.sv]
// Top level of the Morse character encoder: controller plus datapath.
//
//   channel | dir | transaction                     | payload
//   in_i    | in  | one character to send           | character[7:0], led_pin[5:0]
//   out_o   | out | one timed LED segment           | out_pin[5:0], level, units[1:0], last
//
// A character is accepted in idle, then yields the closing gap alone for a non-letter,
// a space segment and the gap for a space, or an on/off pair per symbol and the gap.
// The controller walks the symbols one segment per cycle into a single output
// register; a stall on out_o holds that register and the walk waits.
// in_i is ready whenever the controller is idle, even while the final segment
// of the previous character still waits in the output register.
// Asynchronous active-low reset returns the controller to idle and empties
// the output register.
`default_nettype none

module morse_character_encoder_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mce_in_if.sink    in_i,
  mce_out_if.source out_o
);

  mce_pkg::ctrl_cmd_t  cmd;
  mce_pkg::dp_status_t status;

  // Controller
  mce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  mce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .character_i (in_i.character),
    .led_pin_i   (in_i.led_pin),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_pin_o   (out_o.out_pin),
    .level_o     (out_o.level),
    .units_o     (out_o.units),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

[sv/mce_ctrl.sv]
// Controller state machine: walks the symbols of one character and issues segments.
`default_nettype none

module mce_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mce_pkg::dp_status_t status_i,
  output mce_pkg::ctrl_cmd_t       cmd_o
);

  mce_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      mce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (status_i.in_kind)
            mce_pkg::KIND_LETTER: state_d = mce_pkg::ST_SYM_ON;
            mce_pkg::KIND_SPACE:  state_d = mce_pkg::ST_SPACE;
            default:              state_d = mce_pkg::ST_GAP;
          endcase
        end
      end
      mce_pkg::ST_SYM_ON: begin
        cmd_o.level = 1'b1;
        cmd_o.units = status_i.dash ? mce_pkg::DASH_ON_UNITS : mce_pkg::DOT_ON_UNITS;
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mce_pkg::ST_SYM_OFF;
        end
      end
      mce_pkg::ST_SYM_OFF: begin
        cmd_o.units = mce_pkg::SYMBOL_OFF_UNITS;
        if (status_i.slot_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.shift = 1'b1;
          state_d     = status_i.last_sym ? mce_pkg::ST_GAP : mce_pkg::ST_SYM_ON;
        end
      end
      mce_pkg::ST_SPACE: begin
        cmd_o.units = mce_pkg::SPACE_UNITS;
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mce_pkg::ST_GAP;
        end
      end
      mce_pkg::ST_GAP: begin
        cmd_o.units = mce_pkg::GAP_UNITS;
        cmd_o.last  = 1'b1;
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/mce_dp.sv]
// Datapath: character lookup, symbol shift register and the output register.
`default_nettype none

module mce_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mce_pkg::CharW-1:0]     character_i,
  input  wire logic [mce_pkg::PinW-1:0]      led_pin_i,
  input  wire mce_pkg::ctrl_cmd_t            cmd_i,
  output mce_pkg::dp_status_t                status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mce_pkg::PinW-1:0]           out_pin_o,
  output logic                               level_o,
  output logic [mce_pkg::UnitsW-1:0]         units_o,
  output logic                               last_o
);

  logic                          is_upper, is_lower;
  logic [mce_pkg::CharW-1:0]     ofs;
  logic [mce_pkg::IdxW-1:0]      idx;
  logic [mce_pkg::CountW-1:0]    cnt_in;

  logic [mce_pkg::PinW-1:0]      pin_q;
  logic [mce_pkg::PatW-1:0]      pat_q;
  logic [mce_pkg::CountW-1:0]    cnt_q;
  logic                          out_valid_q, out_valid_d;
  logic [mce_pkg::PinW-1:0]      out_pin_q;
  logic                          level_q;
  logic [mce_pkg::UnitsW-1:0]    units_q;
  logic                          last_q;

  // Classify the incoming character and form the letter index
  assign is_upper = (character_i >= mce_pkg::CHAR_UPPER_A) &&
                    (character_i <= mce_pkg::CHAR_UPPER_Z);
  assign is_lower = (character_i >= mce_pkg::CHAR_LOWER_A) &&
                    (character_i <= mce_pkg::CHAR_LOWER_Z);
  assign ofs      = is_upper ? (character_i - mce_pkg::CHAR_UPPER_A)
                             : (character_i - mce_pkg::CHAR_LOWER_A);
  assign idx      = ofs[mce_pkg::IdxW-1:0];
  assign cnt_in   = mce_pkg::sym_count(idx);

  // Status toward the controller
  always_comb begin
    status_o.last_sym  = (cnt_q == mce_pkg::CountW'(1));
    status_o.dash      = pat_q[mce_pkg::PatW-1];
    status_o.slot_free = !out_valid_q || out_ready_i;
    if (is_upper || is_lower) begin
      status_o.in_kind = mce_pkg::KIND_LETTER;
    end else if (character_i == mce_pkg::CHAR_SPACE) begin
      status_o.in_kind = mce_pkg::KIND_SPACE;
    end else begin
      status_o.in_kind = mce_pkg::KIND_OTHER;
    end
  end

  // Character registers: pin, pattern and remaining symbol count
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pin_q <= led_pin_i;
      pat_q <= mce_pkg::align_pat(mce_pkg::sym_bits(idx), cnt_in);
      cnt_q <= cnt_in;
    end else if (cmd_i.shift) begin
      pat_q <= {pat_q[mce_pkg::PatW-2:0], 1'b0};
      cnt_q <= cnt_q - mce_pkg::CountW'(1);
    end
  end

  // Output valid flag
  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pin_q <= pin_q;
      level_q   <= cmd_i.level;
      units_q   <= cmd_i.units;
      last_q    <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pin_o   = out_pin_q;
  assign level_o     = level_q;
  assign units_o     = units_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[tb/morse_character_encoder_top_tb.sv]
// Testbench for the Morse encoder top level: random and directed characters, segment scoreboard.
`timescale 1ns / 1ps

module morse_character_encoder_top_tb;

  localparam int unsigned RandomChars   = 158;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 24;

  // One character request on the input channel
  typedef struct packed {
    logic [mce_pkg::CharW-1:0] character;
    logic [mce_pkg::PinW-1:0]  led_pin;
  } char_req_t;

  // One timed LED segment on the output channel
  typedef struct packed {
    logic [mce_pkg::PinW-1:0]   pin;
    logic                       level;
    logic [mce_pkg::UnitsW-1:0] units;
    logic                       last;
  } segment_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mce_in_if  char_bus ();
  mce_out_if seg_bus ();

  morse_character_encoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_bus),
    .out_o  (seg_bus)
  );

  char_req_t pending_chars[$];
  segment_t  expected_segments[$];
  int        chars_sent  = 0;
  int        total_chars = 1;
  int        mismatches  = 0;
  int        idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  // Dot/dash string per letter index, first symbol leftmost
  function automatic string morse_pattern(input int idx);
    string p;
    case (idx)
      0:  p = ".-";    1:  p = "-...";  2:  p = "-.-.";  3:  p = "-..";
      4:  p = ".";     5:  p = "..-.";  6:  p = "--.";   7:  p = "....";
      8:  p = "..";    9:  p = ".---";  10: p = "-.-";   11: p = ".-..";
      12: p = "--";    13: p = "-.";    14: p = "---";   15: p = ".--.";
      16: p = "--.-";  17: p = ".-.";   18: p = "...";   19: p = "-";
      20: p = "..-";   21: p = "...-";  22: p = ".--";   23: p = "-..-";
      24: p = "-.--";  25: p = "--..";
      default: p = "";
    endcase
    return p;
  endfunction

  function automatic segment_t make_segment(input logic [mce_pkg::PinW-1:0] pin,
                                            input logic level,
                                            input logic [mce_pkg::UnitsW-1:0] units,
                                            input logic last);
    segment_t s;
    s.pin   = pin;
    s.level = level;
    s.units = units;
    s.last  = last;
    return s;
  endfunction

  // Queue up the segments one character turns into
  task automatic encode_character(input logic [mce_pkg::CharW-1:0] ch,
                                  input logic [mce_pkg::PinW-1:0] pin);
    string pat;
    int    idx;
    idx = -1;
    if (ch >= mce_pkg::CHAR_UPPER_A && ch <= mce_pkg::CHAR_UPPER_Z)
      idx = int'(ch - mce_pkg::CHAR_UPPER_A);
    else if (ch >= mce_pkg::CHAR_LOWER_A && ch <= mce_pkg::CHAR_LOWER_Z)
      idx = int'(ch - mce_pkg::CHAR_LOWER_A);
    if (idx >= 0) begin
      pat = morse_pattern(idx);
      for (int i = 0; i < pat.len(); i++) begin
        expected_segments.push_back(make_segment(pin, 1'b1,
            (pat[i] == "-") ? mce_pkg::DASH_ON_UNITS : mce_pkg::DOT_ON_UNITS, 1'b0));
        expected_segments.push_back(make_segment(pin, 1'b0,
            mce_pkg::SYMBOL_OFF_UNITS, 1'b0));
      end
    end else if (ch == mce_pkg::CHAR_SPACE) begin
      expected_segments.push_back(make_segment(pin, 1'b0, mce_pkg::SPACE_UNITS, 1'b0));
    end
    // closing gap ends every character
    expected_segments.push_back(make_segment(pin, 1'b0, mce_pkg::GAP_UNITS, 1'b1));
  endtask

  // 0: sender light / receiver heavy, 1: swapped, 2: no idling
  function automatic int idle_phase();
    return (chars_sent * 3) / total_chars;
  endfunction

  function automatic bit sender_pause();
    int ph;
    ph = idle_phase();
    if (ph == 0) return $urandom_range(99) < 15;
    if (ph == 1) return $urandom_range(99) < 86;
    return 1'b0;
  endfunction

  function automatic bit receiver_pause();
    int ph;
    ph = idle_phase();
    if (ph == 0) return $urandom_range(99) < 86;
    if (ph == 1) return $urandom_range(99) < 15;
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  function automatic char_req_t make_req(input logic [mce_pkg::CharW-1:0] ch,
                                         input logic [mce_pkg::PinW-1:0] pin);
    char_req_t r;
    r.character = ch;
    r.led_pin   = pin;
    return r;
  endfunction

  // Driver: feed pending characters onto the input channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_bus.valid     <= 1'b0;
      char_bus.character <= '0;
      char_bus.led_pin   <= '0;
    end else begin : drive
      char_req_t req;
      if (char_bus.valid && char_bus.ready) begin
        encode_character(char_bus.character, char_bus.led_pin);
        chars_sent <= chars_sent + 1;
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (pending_chars.size() > 0 && !sender_pause()) begin
          req = pending_chars.pop_front();
          char_bus.valid     <= 1'b1;
          char_bus.character <= req.character;
          char_bus.led_pin   <= req.led_pin;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each segment transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_bus.ready <= 1'b0;
    end else begin : watch
      segment_t want;
      if (seg_bus.valid && seg_bus.ready) begin
        if (expected_segments.size() == 0) begin
          $error("unexpected segment: pin %0d level %0d units %0d last %0d",
                 seg_bus.out_pin, seg_bus.level, seg_bus.units, seg_bus.last);
          mismatches++;
        end else begin
          want = expected_segments.pop_front();
          check_field("out_pin", int'(want.pin), int'(seg_bus.out_pin));
          check_field("level", int'(want.level), int'(seg_bus.level));
          check_field("units", int'(want.units), int'(seg_bus.units));
          check_field("last", int'(want.last), int'(seg_bus.last));
        end
      end
      seg_bus.ready <= !receiver_pause();
    end
  end

  // Watchdog: give up after a long stretch with no transaction on either side
  always @(posedge clk_i) begin
    if ((char_bus.valid && char_bus.ready) || (seg_bus.valid && seg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL morse_character_encoder_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                        pick;
    logic [mce_pkg::CharW-1:0] ch;

    // Directed: letter range edges, neighbors just outside, space, odd codes
    pending_chars.push_back(make_req(mce_pkg::CHAR_UPPER_A, 6'd0));
    pending_chars.push_back(make_req(mce_pkg::CHAR_UPPER_Z, 6'd63));
    pending_chars.push_back(make_req(mce_pkg::CHAR_LOWER_A, 6'd63));
    pending_chars.push_back(make_req(mce_pkg::CHAR_LOWER_Z, 6'd0));
    pending_chars.push_back(make_req(8'h40, 6'd21));   // just below 'A'
    pending_chars.push_back(make_req(8'h5B, 6'd42));   // just above 'Z'
    pending_chars.push_back(make_req(8'h60, 6'd5));    // just below 'a'
    pending_chars.push_back(make_req(8'h7B, 6'd58));   // just above 'z'
    pending_chars.push_back(make_req(mce_pkg::CHAR_SPACE, 6'd63));
    pending_chars.push_back(make_req(mce_pkg::CHAR_SPACE, 6'd0));
    pending_chars.push_back(make_req(8'h00, 6'd0));
    pending_chars.push_back(make_req(8'hFF, 6'd63));
    pending_chars.push_back(make_req(8'h80, 6'd1));
    pending_chars.push_back(make_req(8'h30, 6'd2));    // digit zero
    pending_chars.push_back(make_req(8'h67, 6'd10));   // g: dash dash dot
    pending_chars.push_back(make_req(8'h47, 6'd11));   // G
    pending_chars.push_back(make_req(8'h51, 6'd12));   // Q
    pending_chars.push_back(make_req(8'h65, 6'd13));   // e: single dot
    pending_chars.push_back(make_req(8'h74, 6'd14));   // t: single dash
    pending_chars.push_back(make_req(8'h68, 6'd15));   // h: four dots
    pending_chars.push_back(make_req(8'h6F, 6'd16));   // o: three dashes
    pending_chars.push_back(make_req(8'h59, 6'd17));   // Y

    // Random: mostly letters, some spaces, the rest anything in 0..255
    for (int n = 0; n < RandomChars; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        ch = ($urandom_range(1) ? mce_pkg::CHAR_UPPER_A : mce_pkg::CHAR_LOWER_A)
             + 8'($urandom_range(25));
      end else if (pick < 80) begin
        ch = mce_pkg::CHAR_SPACE;
      end else begin
        ch = 8'($urandom_range(255));
      end
      pending_chars.push_back(make_req(ch, 6'($urandom_range(63))));
    end
    total_chars = pending_chars.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_chars.size() == 0 && !char_bus.valid);
    wait (expected_segments.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_segments.size() != 0) begin
      $error("%0d expected segments never arrived", expected_segments.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS morse_character_encoder_top");
    end else begin
      $display("FAIL morse_character_encoder_top");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mce_pkg.sv
sv/mce_if.sv
sv/mce_ctrl.sv
sv/mce_dp.sv
sv/morse_character_encoder_top.sv
tb/morse_character_encoder_top_tb.sv
